// ===== rtl/nearest_point_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// nearest point matcher assertion macros
// shared concurrent assertion forms, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_MATCHER_DEFINES_SVH
`define NEAREST_POINT_MATCHER_DEFINES_SVH

// condition holds at every edge out of reset
`define NPM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define NPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/npm_pkg.sv =====
// ----------------------------------------------------------------------------
// npm_pkg
// types and constants shared by the nearest point matcher modules
// ----------------------------------------------------------------------------
package npm_pkg;

  localparam int MAX_REFS    = 1024;
  localparam int COORD_BITS  = 20;
  localparam int ID_W        = 16;
  localparam int CNT_W       = $clog2(MAX_REFS + 1);
  localparam int SQ_W        = 2 * COORD_BITS;
  localparam int DIST_W      = SQ_W + 1;
  localparam int IN_FIELDS_W = 2 * COORD_BITS + ID_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ID_W + 2 * COORD_BITS + DIST_W;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } point_t;

  typedef struct packed {
    logic   valid;
    logic   first;
    point_t pt;
  } feed_t;

  typedef struct packed {
    logic              busy;
    point_t            pt;
    logic [DIST_W-1:0] dist_sq;
  } best_t;

  typedef struct packed {
    logic              found;
    point_t            pt;
    logic [DIST_W-1:0] dist_sq;
    logic              full;
  } result_t;

endpackage

// ===== rtl/npm_cell.sv =====
// ----------------------------------------------------------------------------
// npm_cell
// one reference point slot of the rotating store chain
// ----------------------------------------------------------------------------
module npm_cell (
  input  logic            clk,
  input  logic            load_en,
  input  logic            shift_en,
  input  logic            wrap_sel,
  input  npm_pkg::point_t load_pt,
  input  npm_pkg::point_t nbr_pt,
  input  npm_pkg::point_t head_pt,
  output npm_pkg::point_t pt
);

  npm_pkg::point_t pt_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      pt_r <= load_pt;
    end else if (shift_en) begin
      pt_r <= wrap_sel ? head_pt : nbr_pt;
    end
  end

  assign pt = pt_r;

endmodule

// ===== rtl/npm_dist.sv =====
// ----------------------------------------------------------------------------
// npm_dist
// pipelined squared distance and running minimum over the scanned points
// ----------------------------------------------------------------------------
module npm_dist (
  input  logic                           clk,
  input  logic                           rst_n,
  input  npm_pkg::feed_t                 feed,
  input  logic [npm_pkg::COORD_BITS-1:0] qx,
  input  logic [npm_pkg::COORD_BITS-1:0] qy,
  output npm_pkg::best_t                 best
);

  logic                           v1_r, v2_r, v3_r;
  logic                           f1_r, f2_r, f3_r;
  npm_pkg::point_t                p1_r, p2_r, p3_r;
  logic [npm_pkg::COORD_BITS-1:0] dx_r, dy_r;
  logic [npm_pkg::SQ_W-1:0]       dx2_r, dy2_r;
  logic [npm_pkg::DIST_W-1:0]     sum_r;
  npm_pkg::point_t                best_pt_r;
  logic [npm_pkg::DIST_W-1:0]     best_d_r;
  logic [npm_pkg::COORD_BITS-1:0] dx_nxt, dy_nxt;

  always_comb begin
    dx_nxt = (feed.pt.x >= qx) ? (feed.pt.x - qx) : (qx - feed.pt.x);
    dy_nxt = (feed.pt.y >= qy) ? (feed.pt.y - qy) : (qy - feed.pt.y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= feed.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_r  <= feed.first;
    p1_r  <= feed.pt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    f2_r  <= f1_r;
    p2_r  <= p1_r;
    dx2_r <= dx_r * dx_r;
    dy2_r <= dy_r * dy_r;
    f3_r  <= f2_r;
    p3_r  <= p2_r;
    sum_r <= {1'b0, dx2_r} + {1'b0, dy2_r};
    // strict compare keeps the earlier point on a tie
    if (v3_r && (f3_r || (sum_r < best_d_r))) begin
      best_d_r  <= sum_r;
      best_pt_r <= p3_r;
    end
  end

  always_comb begin
    best.busy    = v1_r | v2_r | v3_r;
    best.pt      = best_pt_r;
    best.dist_sq = best_d_r;
  end

endmodule

// ===== rtl/nearest_point_matcher.sv =====
// ----------------------------------------------------------------------------
// nearest_point_matcher
// brute force 2-D nearest point search over a rotating chain of point cells
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                  tuser (low bit up)
// in_      in   pos_x, pos_y, point_id              cmd
// out_     out  match_id, match_x, match_y,         match_found, store_full
//               distance_sq, zero fill
//
// clear and load pass from accept through res_r and the hold state to the result register
// a query to n stored points rotates the chain one cell
//   per cycle past a single multiply pipeline, wrapping at the fill count
// a query to an empty store skips the scan and reports no match
// one item at a time; a finished result waits in the output register
// reset empties the store; point cells are not cleared
`include "nearest_point_matcher_defines.svh"

module nearest_point_matcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [npm_pkg::IN_DATA_W-1:0] in_tdata,   // pos_x, pos_y, point_id
  input  logic [1:0]                    in_tuser,   // cmd
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [npm_pkg::OUT_DATA_W-1:0] out_tdata, // match_id, match_x, match_y, distance_sq
  output logic [1:0]                    out_tuser   // match_found, store_full
);

  npm_pkg::state_t                state_r, state_nxt;
  logic [npm_pkg::CNT_W-1:0]      count_r, count_nxt, count_m1;
  logic [npm_pkg::CNT_W-1:0]      scan_r;
  logic [npm_pkg::COORD_BITS-1:0] qx_r, qy_r;
  npm_pkg::result_t               res_r, res_nxt, out_res_r;
  logic                           out_valid_r;
  logic                           in_fire, out_load, shift_en, load_en, full;
  npm_pkg::cmd_t                  cmd;
  npm_pkg::point_t                in_pt;
  npm_pkg::point_t                cell_pt [npm_pkg::MAX_REFS];
  npm_pkg::feed_t                 feed;
  npm_pkg::best_t                 best;

  assign cmd      = npm_pkg::cmd_t'(in_tuser);
  assign in_pt.x  = in_tdata[npm_pkg::COORD_BITS-1:0];
  assign in_pt.y  = in_tdata[2*npm_pkg::COORD_BITS-1:npm_pkg::COORD_BITS];
  assign in_pt.id = in_tdata[npm_pkg::IN_FIELDS_W-1:2*npm_pkg::COORD_BITS];
  assign in_fire  = in_tvalid & in_tready;
  assign count_m1 = count_r - 1'b1;
  assign full     = (count_r == npm_pkg::CNT_W'(npm_pkg::MAX_REFS));
  assign load_en  = in_fire && (cmd == npm_pkg::CMD_LOAD) && !full;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      npm_pkg::ST_IDLE: begin
        if (in_fire) begin
          if ((cmd == npm_pkg::CMD_QUERY) && (count_r != '0)) begin
            state_nxt = npm_pkg::ST_SCAN;
          end else begin
            state_nxt = npm_pkg::ST_HOLD;
          end
        end
      end
      npm_pkg::ST_SCAN: begin
        if (scan_r == count_m1) begin
          state_nxt = npm_pkg::ST_DRAIN;
        end
      end
      npm_pkg::ST_DRAIN: begin
        if (!best.busy) begin
          state_nxt = npm_pkg::ST_HOLD;
        end
      end
      npm_pkg::ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = npm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npm_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    shift_en  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      npm_pkg::ST_IDLE:  in_tready = 1'b1;
      npm_pkg::ST_SCAN:  shift_en  = 1'b1;
      npm_pkg::ST_DRAIN: ;
      npm_pkg::ST_HOLD:  out_load  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_comb begin
    res_nxt   = res_r;
    count_nxt = count_r;
    if (in_fire) begin
      res_nxt = '0;
      case (cmd)
        npm_pkg::CMD_CLEAR: count_nxt = '0;
        npm_pkg::CMD_LOAD: begin
          if (full) begin
            res_nxt.full = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        default: ;
      endcase
    end else if ((state_r == npm_pkg::ST_DRAIN) && !best.busy) begin
      res_nxt.found   = 1'b1;
      res_nxt.pt      = best.pt;
      res_nxt.dist_sq = best.dist_sq;
      res_nxt.full    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npm_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_fire) begin
      qx_r   <= in_pt.x;
      qy_r   <= in_pt.y;
      scan_r <= '0;
    end else if (shift_en) begin
      scan_r <= scan_r + 1'b1;
    end
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  // point chain, rotating toward cell 0 and wrapping at the fill count
  for (genvar i = 0; i < npm_pkg::MAX_REFS; i++) begin : g_cell
    npm_pkg::point_t nbr;
    if (i == npm_pkg::MAX_REFS - 1) begin : g_last
      assign nbr = cell_pt[0];
    end else begin : g_mid
      assign nbr = cell_pt[i+1];
    end
    npm_cell u_cell (
      .clk      (clk),
      .load_en  (load_en && (count_r == npm_pkg::CNT_W'(i))),
      .shift_en (shift_en),
      .wrap_sel (count_m1 == npm_pkg::CNT_W'(i)),
      .load_pt  (in_pt),
      .nbr_pt   (nbr),
      .head_pt  (cell_pt[0]),
      .pt       (cell_pt[i])
    );
  end

  always_comb begin
    feed.valid = shift_en;
    feed.first = (scan_r == '0);
    feed.pt    = cell_pt[0];
  end

  npm_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .feed  (feed),
    .qx    (qx_r),
    .qy    (qy_r),
    .best  (best)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = npm_pkg::OUT_DATA_W'({out_res_r.dist_sq, out_res_r.pt.y,
                                            out_res_r.pt.x, out_res_r.pt.id});
  assign out_tuser  = {out_res_r.full, out_res_r.found};

  `NPM_ASSERT_ALWAYS(a_count_bound, count_r <= npm_pkg::CNT_W'(npm_pkg::MAX_REFS),
                     "fill count past store depth")
  `NPM_ASSERT_ALWAYS(a_scan_in_range, (state_r != npm_pkg::ST_SCAN) || (scan_r < count_r),
                     "scan index past fill count")
  `NPM_ASSERT_NEXT(a_empty_query, in_fire && (cmd == npm_pkg::CMD_QUERY) && (count_r == '0),
                   (state_r == npm_pkg::ST_HOLD) && !res_r.found,
                   "empty store query reported a match")

endmodule
